// ===== rtl/core/sdq_pkg.sv =====
// ============================================================================
// sdq_pkg
// Shared types and constants for the sorted double-ended queue.
// ============================================================================
`default_nettype none

package sdq_pkg;

    // Field widths of the request and response transactions
    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    // Parameter defaults
    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REM_MIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REM_MAX = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch request, set up status and walk index
        logic ins_read;    // read entry below the walk index
        logic ins_shift;   // move read entry up one slot, step index down
        logic ins_place;   // write new value at walk index, count up
        logic rem_read;    // read the end being removed
        logic rem_commit;  // take read value, count down, move head if needed
        logic post;        // load the response register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic j_zero;      // walk index reached the bottom
        logic ge;          // read entry is not smaller than the new value
        logic slot_free;   // response register can take a new transaction
    } ctl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/sdq_ram.sv =====
// ============================================================================
// sdq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module sdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sdq_ctrl.sv =====
// ============================================================================
// sdq_ctrl
// Sequencer for insert walk, end removal and response posting.
// ============================================================================
`default_nettype none

module sdq_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    input  wire logic [sdq_pkg::CMD_W-1:0] req_command,
    input  wire sdq_pkg::ctl_stat_t        stat,
    output      logic                      req_ready,
    output      sdq_pkg::ctl_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_REM_RD,
        S_REM_TAKE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    if (req_command == sdq_pkg::CMD_INSERT && !stat.full)
                    begin
                        state_next = S_INS_RD;
                    end
                    else if ((req_command inside {sdq_pkg::CMD_REM_MIN,
                                                  sdq_pkg::CMD_REM_MAX}) && !stat.empty)
                    begin
                        state_next = S_REM_RD;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_INS_RD:
            begin
                if (stat.j_zero)
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_RESULT;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (stat.ge)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = S_INS_RD;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_REM_RD:
            begin
                cmd.rem_read = 1'b1;
                state_next   = S_REM_TAKE;
            end
            S_REM_TAKE:
            begin
                cmd.rem_commit = 1'b1;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.slot_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sdq_datapath.sv =====
// ============================================================================
// sdq_datapath
// Circular sorted store, walk index, head pointer and response register.
// ============================================================================
`default_nettype none

module sdq_datapath #(
    parameter int CAPACITY   = sdq_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sdq_pkg::VALUE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sdq_pkg::req_t      req_data,
    input  wire sdq_pkg::ctl_cmd_t  cmd,
    input  wire logic               rsp_ready,
    output      sdq_pkg::ctl_stat_t stat,
    output      logic               rsp_valid,
    output      sdq_pkg::rsp_t      rsp_data
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Logical index to physical slot, store is circular from head_reg
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [PTR_W-1:0] idx);
        logic [PTR_W:0] sum;
        begin
            sum = {1'b0, head} + {1'b0, idx};
            if (sum >= (PTR_W+1)'(CAPACITY))
            begin
                sum = sum - (PTR_W+1)'(CAPACITY);
            end
            return sum[PTR_W-1:0];
        end
    endfunction

    logic [PTR_W-1:0]               head_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               j_reg;
    logic signed [VALUE_BITS-1:0]   value_reg;
    logic                           op_max_reg;
    logic [sdq_pkg::STAT_W-1:0]     status_reg;
    logic signed [sdq_pkg::VALUE_W-1:0] removed_reg;
    logic                           rsp_valid_reg;
    sdq_pkg::rsp_t                  rsp_data_reg;

    logic signed [VALUE_BITS-1:0]   in_conv;
    logic signed [VALUE_BITS-1:0]   rd_data;
    logic signed [sdq_pkg::VALUE_W-1:0] rd_conv;
    logic [CNT_W-1:0]               j_dec;
    logic [CNT_W-1:0]               cnt_dec;
    logic [PTR_W-1:0]               head_inc;
    logic [PTR_W-1:0]               raddr;
    logic [PTR_W-1:0]               waddr;
    logic [VALUE_BITS-1:0]          wdata;
    logic                           we;
    logic                           re;

    // Value width adaptation between the 32-bit fields and the store
    if (VALUE_BITS <= sdq_pkg::VALUE_W)
    begin : g_narrow
        assign in_conv = req_data.value[VALUE_BITS-1:0];
    end
    else
    begin : g_wide
        assign in_conv = {{(VALUE_BITS-sdq_pkg::VALUE_W){1'b0}}, req_data.value};
    end

    if (VALUE_BITS >= sdq_pkg::VALUE_W)
    begin : g_out_trunc
        assign rd_conv = rd_data[sdq_pkg::VALUE_W-1:0];
    end
    else
    begin : g_out_sext
        assign rd_conv = {{(sdq_pkg::VALUE_W-VALUE_BITS){rd_data[VALUE_BITS-1]}}, rd_data};
    end

    assign j_dec    = j_reg - CNT_W'(1);
    assign cnt_dec  = count_reg - CNT_W'(1);
    assign head_inc = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + PTR_W'(1);

    always_comb
    begin
        re    = cmd.ins_read | cmd.rem_read;
        we    = cmd.ins_shift | cmd.ins_place;
        wdata = cmd.ins_shift ? rd_data : value_reg;
        waddr = phys(head_reg, j_reg[PTR_W-1:0]);
        if (cmd.rem_read)
        begin
            raddr = op_max_reg ? phys(head_reg, cnt_dec[PTR_W-1:0]) : head_reg;
        end
        else
        begin
            raddr = phys(head_reg, j_dec[PTR_W-1:0]);
        end
    end

    sdq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_comb
    begin
        stat.full      = (count_reg >= CAP_CNT);
        stat.empty     = (count_reg == '0);
        stat.j_zero    = (j_reg == '0);
        stat.ge        = (rd_data >= value_reg);
        stat.slot_free = !rsp_valid_reg || rsp_ready;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            j_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                j_reg <= count_reg;
            end
            else if (cmd.ins_shift)
            begin
                j_reg <= j_dec;
            end
            if (cmd.ins_place)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.rem_commit)
            begin
                count_reg <= cnt_dec;
                if (!op_max_reg)
                begin
                    head_reg <= head_inc;
                end
            end
            if (cmd.post)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg   <= in_conv;
            op_max_reg  <= (req_data.command == sdq_pkg::CMD_REM_MAX);
            removed_reg <= '0;
            if (req_data.command == sdq_pkg::CMD_INSERT && stat.full)
            begin
                status_reg <= sdq_pkg::ST_FULL;
            end
            else if ((req_data.command inside {sdq_pkg::CMD_REM_MIN,
                                               sdq_pkg::CMD_REM_MAX}) && stat.empty)
            begin
                status_reg <= sdq_pkg::ST_EMPTY;
            end
            else
            begin
                status_reg <= sdq_pkg::ST_DONE;
            end
        end
        if (cmd.rem_commit)
        begin
            removed_reg <= rd_conv;
        end
        if (cmd.post)
        begin
            rsp_data_reg.status        <= status_reg;
            rsp_data_reg.removed_value <= removed_reg;
            rsp_data_reg.count         <= sdq_pkg::COUNT_W'(count_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("count above capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= PTR_W'(CAPACITY - 1))
        else $error("head pointer out of range");

    a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_place |-> (count_reg < CAP_CNT) && (j_reg <= count_reg))
        else $error("insert with no room or walk index past count");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rem_read || cmd.rem_commit) |-> (count_reg != '0))
        else $error("removal from empty store");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.post && status_reg == sdq_pkg::ST_FULL) |-> (count_reg == CAP_CNT))
        else $error("full status posted below capacity");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sorted_double_ended_queue_top.sv =====
// ============================================================================
// sorted_double_ended_queue_top
// Double-ended priority queue over a sorted circular store.
// ============================================================================
//
//  channel   | handshake              | payload         | direction
//  ----------+------------------------+-----------------+----------
//  request   | req_valid / req_ready  | req_data (req_t)| in
//  response  | rsp_valid / rsp_ready  | rsp_data (rsp_t)| out
//
// Each transaction uses the one store read port, whose read is registered:
// an insert reads and compares each entry it moves up, then writes the new
// value; a removal reads one end, then takes it; a rejected command or the
// unused code goes straight to the response. One request at a time.
// Reset (rst_n low, asynchronous) empties the queue; the store is not cleared.
// A held response stalls only the posting of the next one, not its accept.
// ============================================================================
`default_nettype none

module sorted_double_ended_queue_top #(
    parameter int CAPACITY   = sdq_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sdq_pkg::VALUE_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_ready,
    input  wire sdq_pkg::req_t req_data,
    output      logic          rsp_valid,
    input  wire logic          rsp_ready,
    output      sdq_pkg::rsp_t rsp_data
);

    // Command and status between sequencer and datapath
    sdq_pkg::ctl_cmd_t  ctl_cmd;
    sdq_pkg::ctl_stat_t ctl_stat;

    // Sequencer: accepts a request only when idle, then walks the store
    sdq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req_data.command),
        .stat        (ctl_stat),
        .req_ready   (req_ready),
        .cmd         (ctl_cmd)
    );

    // Datapath: circular store (head pointer makes remove-smallest cheap),
    // insertion by shifting entries not smaller than the new value up one at a time from the top
    sdq_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (ctl_cmd),
        .rsp_ready (rsp_ready),
        .stat      (ctl_stat),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire
